FILE: rtl/core/paillier_crypto_unit_core_macros.svh
// assertion macros for the paillier unit checker
// no dependencies
`ifndef PAILLIER_CRYPTO_UNIT_CORE_MACROS_SVH
`define PAILLIER_CRYPTO_UNIT_CORE_MACROS_SVH
`define PCU_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication failed");
`define PCU_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");
`endif

FILE: rtl/core/pcu_pkg.sv
// shared constants and types for the paillier unit
// no dependencies
package pcu_pkg;
  localparam int KeyBits = 16;
  localparam int ExpCntW = $clog2(KeyBits + 1);
  localparam int MulCntW = 6;
  localparam int CfgIdxW = 3;
  typedef enum logic [1:0] {
    ACT_ENCRYPT = 2'd0,
    ACT_DECRYPT = 2'd1,
    ACT_ADD     = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;
  localparam logic [CfgIdxW-1:0] REG_GEN  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_N    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_NSQ  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LAM  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MU   = 3'd4;
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } mul_ctl_t;
endpackage

FILE: rtl/core/pcu_modmul.sv
// bit-serial modular multiplier: a*b mod m, one multiplier bit per cycle
// depends on pcu_pkg
module pcu_modmul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] m,
  output pcu_pkg::mul_ctl_t ctl,
  output logic [31:0] p
);
  typedef enum logic [1:0] {S_IDLE, S_RA, S_RUN} st_t;
  st_t st_r;
  logic [31:0] a_r, b_r, acc_r, m_r;
  logic [pcu_pkg::MulCntW-1:0] cnt_r;
  logic done_r;
  logic last_bit;
  logic [33:0] dbl, add1;
  logic [32:0] red;
  assign last_bit = (cnt_r == pcu_pkg::MulCntW'(31));
  // horner reduction of the a operand, one bit of a per cycle
  always_comb begin
    red = {acc_r, a_r[31]};
    if (red >= {1'b0, m_r}) red = red - {1'b0, m_r};
  end
  always_comb begin
    dbl = {1'b0, acc_r, 1'b0};
    if (dbl >= {2'b0, m_r}) dbl = dbl - {2'b0, m_r};
    add1 = dbl + (b_r[31] ? {2'b0, a_r} : 34'd0);
    if (add1 >= {2'b0, m_r}) add1 = add1 - {2'b0, m_r};
  end
  always_ff @(posedge clk) begin
    done_r <= rst_n && ((st_r == S_RA && m_r == '0) || (st_r == S_RUN && last_bit));
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: if (start) begin
          a_r <= a; b_r <= b; m_r <= m; acc_r <= '0; cnt_r <= '0; st_r <= S_RA;
        end
        S_RA: begin
          if (m_r == '0) begin
            acc_r <= '0; st_r <= S_IDLE;
          end else if (last_bit) begin
            a_r <= red[31:0]; acc_r <= '0; cnt_r <= '0; st_r <= S_RUN;
          end else begin
            a_r <= {a_r[30:0], 1'b0}; acc_r <= red[31:0];
            cnt_r <= cnt_r + pcu_pkg::MulCntW'(1);
          end
        end
        S_RUN: begin
          acc_r <= add1[31:0];
          b_r <= {b_r[30:0], 1'b0};
          cnt_r <= cnt_r + pcu_pkg::MulCntW'(1);
          if (last_bit) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
  assign ctl.start = start;
  assign ctl.busy = (st_r != S_IDLE);
  assign ctl.done = done_r;
  assign p = acc_r;
endmodule

FILE: rtl/core/pcu_divider.sv
// restoring divider for the decrypt tail: (x-1)/n, one quotient bit per cycle
// depends on pcu_pkg
module pcu_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [31:0] quo
);
  logic [31:0] q_r;
  logic [16:0] rem_r;
  logic [15:0] den_r;
  logic [pcu_pkg::MulCntW-1:0] cnt_r;
  logic run_r, done_r;
  logic last_bit;
  logic [17:0] sh;
  logic [17:0] diff;
  assign sh = {rem_r, q_r[31]};
  assign diff = sh - {2'b0, den_r};
  assign last_bit = (cnt_r == pcu_pkg::MulCntW'(31));
  always_ff @(posedge clk) begin
    done_r <= rst_n && !start && run_r && last_bit;
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (start) begin
      q_r <= num; rem_r <= '0; den_r <= den; cnt_r <= '0; run_r <= 1'b1;
    end else if (run_r) begin
      if (!diff[17]) begin
        rem_r <= diff[16:0]; q_r <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= sh[16:0]; q_r <= {q_r[30:0], 1'b0};
      end
      cnt_r <= cnt_r + pcu_pkg::MulCntW'(1);
      if (last_bit) run_r <= 1'b0;
    end
  end
  assign done = done_r;
  assign quo = q_r;
endmodule

FILE: rtl/core/paillier_crypto_unit_core.sv
// Paillier unit top level: sequencer over a shared serial modular multiplier
// depends on pcu_pkg, pcu_modmul, pcu_divider
//
// usage: drive in_action, in_ciphertext, in_plaintext, in_blinding and pulse
// start while busy is low; the beat is taken at that edge and busy rises.
// the result appears on out_result with out_valid high for exactly one cycle,
// and busy falls in that same cycle; the receiver cannot stall, so the
// result must be taken. configuration: cfg_we, cfg_index, cfg_wdata
// write one key register per edge; the user must write them only while busy
// is low, as the block itself does not enforce it. reset loads the default
// key and clears busy. each modular multiply first reduces the first operand
// bit by bit, then multiplies, with start and done handshakes around it.
// each exponent bit takes a squaring, and a multiply first when it is set.
// encrypt runs two 16-bit square-and-multiply ladders (up to 64 multiplies)
// plus one final multiply; add adds one more multiply. decrypt runs one
// ladder, a divide and one multiply. an unused action, zero n^2 in encrypt
// or add, or zero n in decrypt go straight to the output state with zero.
// one item is in flight at a time; the serial multiplier sets the pace.
module paillier_crypto_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_ciphertext,
  input  logic [15:0] in_plaintext,
  input  logic [15:0] in_blinding,
  output logic        out_valid,
  output logic [31:0] out_result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  typedef enum logic [3:0] {
    S_IDLE, S_POW_MUL, S_POW_SQ, S_POW_NEXT, S_POW_DONE,
    S_FIN_MUL, S_DIV, S_MU_MUL, S_OUT
  } st_t;
  st_t st_r;
  logic [31:0] gen_r, nsq_r;
  logic [15:0] n_r, lam_r, mu_r;
  logic [1:0] act_r;
  logic [31:0] c_r, acc_r, base_r, gm_r, res_r;
  logic [15:0] m_r, r_r, e_r;
  logic [pcu_pkg::ExpCntW-1:0] bit_r;
  logic [1:0] phase_r;  // 0: g^m or c^lam, 1: r^n, 2: combine, 3: add mul
  logic waiting_r, busy_r, valid_r;
  logic mul_go;
  logic [31:0] mul_a, mul_b, mul_m, mul_p;
  pcu_pkg::mul_ctl_t mul_ctl;
  logic div_go, div_done;
  logic [31:0] div_q;

  pcu_modmul u_mul (.clk, .rst_n, .start(mul_go), .a(mul_a), .b(mul_b), .m(mul_m),
    .ctl(mul_ctl), .p(mul_p));
  pcu_divider u_div (.clk, .rst_n, .start(div_go), .num(acc_r - 32'd1), .den(n_r),
    .done(div_done), .quo(div_q));

  always_comb begin
    mul_go = 1'b0; mul_a = acc_r; mul_b = base_r; mul_m = nsq_r; div_go = 1'b0;
    unique case (st_r)
      S_POW_MUL: mul_go = !waiting_r && e_r[0];
      S_POW_SQ: begin mul_go = !waiting_r; mul_a = base_r; end
      S_FIN_MUL: begin mul_go = !waiting_r; mul_a = gm_r; mul_b = acc_r; end
      S_DIV: div_go = !waiting_r;
      S_MU_MUL: begin
        mul_go = !waiting_r; mul_a = div_q; mul_b = {16'd0, mu_r};
        mul_m = {16'd0, n_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    valid_r <= rst_n && (st_r == S_OUT);
    if (!rst_n) begin
      st_r <= S_IDLE; busy_r <= 1'b0; waiting_r <= 1'b0;
      gen_r <= 32'd46822; n_r <= 16'd48443; nsq_r <= 32'd2346724249;
      lam_r <= 16'd24000; mu_r <= 16'd3390;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pcu_pkg::REG_GEN: gen_r <= cfg_wdata;
          pcu_pkg::REG_N:   n_r <= cfg_wdata[15:0];
          pcu_pkg::REG_NSQ: nsq_r <= cfg_wdata;
          pcu_pkg::REG_LAM: lam_r <= cfg_wdata[15:0];
          pcu_pkg::REG_MU:  mu_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      unique case (st_r)
        S_IDLE: if (start) begin
          busy_r <= 1'b1; act_r <= in_action; c_r <= in_ciphertext;
          m_r <= in_plaintext; r_r <= in_blinding; phase_r <= 2'd0; bit_r <= '0;
          waiting_r <= 1'b0;
          acc_r <= (nsq_r == 32'd1) ? 32'd0 : 32'd1;
          if (in_action == pcu_pkg::ACT_DECRYPT) begin
            base_r <= in_ciphertext; e_r <= lam_r;
            if (n_r == 16'd0) begin res_r <= '0; st_r <= S_OUT; end
            else st_r <= S_POW_MUL;
          end else if (in_action == pcu_pkg::ACT_NONE || nsq_r == 32'd0) begin
            res_r <= '0; st_r <= S_OUT;
          end else begin
            base_r <= gen_r; e_r <= in_plaintext; st_r <= S_POW_MUL;
          end
        end
        S_POW_MUL: begin
          if (!e_r[0] && !waiting_r) begin
            // still reduce the base via the squaring multiply
            st_r <= S_POW_SQ;
          end else if (mul_go) waiting_r <= 1'b1;
          else if (mul_ctl.done) begin
            acc_r <= mul_p; waiting_r <= 1'b0; st_r <= S_POW_SQ;
          end
        end
        S_POW_SQ: begin
          if (mul_go) waiting_r <= 1'b1;
          else if (mul_ctl.done) begin
            base_r <= mul_p; waiting_r <= 1'b0; st_r <= S_POW_NEXT;
          end
        end
        S_POW_NEXT: begin
          e_r <= {1'b0, e_r[15:1]}; bit_r <= bit_r + pcu_pkg::ExpCntW'(1);
          if (bit_r == pcu_pkg::ExpCntW'(pcu_pkg::KeyBits - 1)) st_r <= S_POW_DONE;
          else st_r <= S_POW_MUL;
        end
        S_POW_DONE: begin
          bit_r <= '0;
          if (act_r == pcu_pkg::ACT_DECRYPT) begin
            if (nsq_r == 32'd0) acc_r <= '0;
            if (acc_r == 32'd0 || nsq_r == 32'd0) begin
              res_r <= '0; st_r <= S_OUT;
            end else st_r <= S_DIV;
          end else if (phase_r == 2'd0) begin
            gm_r <= acc_r; acc_r <= (nsq_r == 32'd1) ? 32'd0 : 32'd1;
            base_r <= {16'd0, r_r}; e_r <= n_r; phase_r <= 2'd1; st_r <= S_POW_MUL;
          end else begin
            phase_r <= 2'd2; st_r <= S_FIN_MUL;
          end
        end
        S_FIN_MUL: begin
          if (mul_go) waiting_r <= 1'b1;
          else if (mul_ctl.done) begin
            waiting_r <= 1'b0;
            if (act_r == pcu_pkg::ACT_ADD && phase_r == 2'd2) begin
              gm_r <= c_r; acc_r <= mul_p; phase_r <= 2'd3;
            end else begin
              res_r <= mul_p; st_r <= S_OUT;
            end
          end
        end
        S_DIV: begin
          if (div_go) waiting_r <= 1'b1;
          else if (div_done) begin waiting_r <= 1'b0; st_r <= S_MU_MUL; end
        end
        S_MU_MUL: begin
          if (mul_go) waiting_r <= 1'b1;
          else if (mul_ctl.done) begin
            waiting_r <= 1'b0; res_r <= mul_p; st_r <= S_OUT;
          end
        end
        S_OUT: begin
          busy_r <= 1'b0; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
  assign busy = busy_r;
  assign out_valid = valid_r;
  assign out_result = res_r;
endmodule

FILE: rtl/core/pcu_checker.sv
// port-level checker for the paillier unit, bound to the top level
// depends on paillier_crypto_unit_core_macros.svh
`include "paillier_crypto_unit_core_macros.svh"
module pcu_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  `PCU_ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy)
  `PCU_ASSERT_IMPL(a_valid_idle, clk, rst_n, out_valid, !busy)
  `PCU_ASSERT_NEXT(a_one_beat, clk, rst_n, out_valid, !out_valid)
  `PCU_ASSERT_IMPL(a_valid_after_busy, clk, rst_n, out_valid, $past(busy))
endmodule
bind paillier_crypto_unit_core pcu_checker u_pcu_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid));

FILE: test/tb_paillier_crypto_unit_core.sv
// self-checking bench for paillier_crypto_unit_core: directed table then random beats
// depends on pcu_pkg and the paillier unit rtl; predicts results with exact modular math
module tb_paillier_crypto_unit_core;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = 2'd0;
  logic [31:0] in_ciphertext = '0;
  logic [15:0] in_plaintext = '0;
  logic [15:0] in_blinding = '0;
  logic        out_valid;
  logic [31:0] out_result;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  paillier_crypto_unit_core DUT (.*);

  always #10 clk = ~clk;

  // key registers as the predictor sees them
  logic [31:0] key_g, key_nsq;
  logic [15:0] key_n, key_lam, key_mu;

  logic [31:0] pending_results[$];
  int          err_cnt = 0;
  longint      cyc = 0;
  // watchdog bound on the whole run of 291 items
  localparam longint CycLimit = 6_000_000;

  typedef struct {
    pcu_pkg::action_t act;
    logic [31:0] c;
    logic [15:0] m;
    logic [15:0] r;
    logic        has_exp;
    logic [31:0] exp_val;
  } vec_t;

  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] md);
    if (md == 64'd0) return 64'd0;
    return ((a % md) * (b % md)) % md;
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] b, logic [15:0] e, logic [63:0] md);
    logic [63:0] acc;
    logic [63:0] sq;
    if (md == 64'd0) return 64'd0;
    acc = 64'd1 % md;
    sq = b % md;
    for (int i = 0; i < pcu_pkg::KeyBits; i++) begin
      if (e[i]) acc = mulmod(acc, sq, md);
      sq = mulmod(sq, sq, md);
    end
    return acc;
  endfunction

  function automatic logic [31:0] paillier_result(pcu_pkg::action_t act, logic [31:0] c,
                                                  logic [15:0] m, logic [15:0] r);
    logic [63:0] enc;
    logic [63:0] x;
    logic [63:0] ell;
    logic [63:0] prod;
    enc = mulmod(powmod(key_g, m, key_nsq), powmod(r, key_n, key_nsq), key_nsq);
    case (act)
      pcu_pkg::ACT_ENCRYPT: return enc[31:0];
      pcu_pkg::ACT_ADD: begin
        prod = mulmod(c, enc, key_nsq);
        return prod[31:0];
      end
      pcu_pkg::ACT_DECRYPT: begin
        if (key_n == 16'd0) return 32'd0;
        x = powmod(c, key_lam, key_nsq);
        ell = (x == 64'd0) ? 64'd0 : (x - 64'd1) / key_n;
        prod = (ell * key_mu) % key_n;
        return prod[31:0];
      end
      default: return 32'd0;
    endcase
  endfunction

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CycLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result: unexpected beat, actual %0d", out_result);
        err_cnt++;
      end else begin
        if (out_result !== pending_results[0]) begin
          $error("result: expected %0d actual %0d", pending_results[0], out_result);
          err_cnt++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  // drives one register write; the caller drops cfg_we after the last one
  task automatic write_key(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      pcu_pkg::REG_GEN: key_g = val;
      pcu_pkg::REG_N:   key_n = val[15:0];
      pcu_pkg::REG_NSQ: key_nsq = val;
      pcu_pkg::REG_LAM: key_lam = val[15:0];
      pcu_pkg::REG_MU:  key_mu = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    wait_cycles(4);
  endtask

  task automatic set_key(logic [31:0] g, logic [15:0] n, logic [31:0] nsq,
                         logic [15:0] lam, logic [15:0] mu);
    drain();
    write_key(pcu_pkg::REG_GEN, g);
    write_key(pcu_pkg::REG_N, {16'd0, n});
    write_key(pcu_pkg::REG_NSQ, nsq);
    write_key(pcu_pkg::REG_LAM, {16'd0, lam});
    write_key(pcu_pkg::REG_MU, {16'd0, mu});
    cfg_we <= 1'b0;
  endtask

  // one beat: random gap, raise start, hold until busy is seen low at an edge
  task automatic send_beat(pcu_pkg::action_t act, logic [31:0] c, logic [15:0] m,
                           logic [15:0] r, logic has_exp, logic [31:0] exp_val);
    wait_cycles($urandom_range(0, 6));
    start <= 1'b1;
    in_action <= act;
    in_ciphertext <= c;
    in_plaintext <= m;
    in_blinding <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(has_exp ? exp_val : paillier_result(act, c, m, r));
    start <= 1'b0;
    // let busy rise before the next beat is offered
    @(posedge clk);
  endtask

  vec_t dir_tab[] = '{
    '{pcu_pkg::ACT_ENCRYPT, 32'd0, 16'd0, 16'd1, 1'b1, 32'd1},
    '{pcu_pkg::ACT_ENCRYPT, 32'd0, 16'd5, 16'd0, 1'b1, 32'd0},
    '{pcu_pkg::ACT_ENCRYPT, 32'd0, 16'd1, 16'd1, 1'b0, 32'd0},
    '{pcu_pkg::ACT_ENCRYPT, 32'd0, 16'hFFFF, 16'hFFFF, 1'b0, 32'd0},
    '{pcu_pkg::ACT_ENCRYPT, 32'd0, 16'd1234, 16'd48441, 1'b0, 32'd0},
    '{pcu_pkg::ACT_DECRYPT, 32'd0, 16'd0, 16'd0, 1'b1, 32'd0},
    '{pcu_pkg::ACT_DECRYPT, 32'd1, 16'd0, 16'd0, 1'b1, 32'd0},
    '{pcu_pkg::ACT_DECRYPT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'd0},
    '{pcu_pkg::ACT_DECRYPT, 32'd2346724249, 16'd0, 16'd0, 1'b1, 32'd0},
    '{pcu_pkg::ACT_DECRYPT, 32'd123456789, 16'd0, 16'd0, 1'b0, 32'd0},
    '{pcu_pkg::ACT_ADD, 32'd0, 16'd7, 16'd3, 1'b1, 32'd0},
    '{pcu_pkg::ACT_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'd0},
    '{pcu_pkg::ACT_ADD, 32'd1, 16'd0, 16'd1, 1'b1, 32'd1},
    '{pcu_pkg::ACT_ADD, 32'd99999, 16'd42, 16'd17, 1'b0, 32'd0},
    '{pcu_pkg::ACT_NONE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'd0},
    '{pcu_pkg::ACT_NONE, 32'd0, 16'd0, 16'd0, 1'b1, 32'd0}
  };

  task automatic random_beats(int count);
    pcu_pkg::action_t act;
    logic [31:0] c;
    logic [15:0] r;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0: act = pcu_pkg::ACT_NONE;
        1, 2, 3, 4, 5, 6: act = pcu_pkg::ACT_ENCRYPT;
        7, 8, 9, 10, 11, 12: act = pcu_pkg::ACT_DECRYPT;
        default: act = pcu_pkg::ACT_ADD;
      endcase
      c = $urandom();
      // ciphertexts mostly valid for the key, sometimes above n^2
      if (key_nsq != 0 && $urandom_range(0, 3) != 0) c = c % key_nsq;
      r = $urandom_range(0, 9) == 0 ? 16'($urandom()) :
          16'($urandom_range(1, (key_n > 3) ? key_n - 2 : 1));
      send_beat(act, c, 16'($urandom()), r, 1'b0, 32'd0);
    end
  endtask

  initial begin
    key_g = 32'd46822;
    key_n = 16'd48443;
    key_nsq = 32'd2346724249;
    key_lam = 16'd24000;
    key_mu = 16'd3390;
    wait_cycles(9);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_beat(dir_tab[i].act, dir_tab[i].c, dir_tab[i].m, dir_tab[i].r,
                dir_tab[i].has_exp, dir_tab[i].exp_val);
    random_beats(80);

    // small toy key: n = 33, lambda = 10
    set_key(32'd34, 16'd33, 32'd1089, 16'd10, 16'd1);
    random_beats(50);
    // zero n^2 and zero n: everything collapses to zero
    set_key(32'hFFFF_FFFF, 16'd0, 32'd0, 16'hFFFF, 16'hFFFF);
    random_beats(20);
    // extremes: generator equal to n^2, largest fields
    set_key(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    random_beats(50);
    // zero exponent and generator
    set_key(32'd0, 16'd1, 32'd1, 16'd0, 16'd0);
    random_beats(15);
    set_key(32'd46822, 16'd48443, 32'd2346724249, 16'd24000, 16'd3390);
    random_beats(60);

    drain();
    wait_cycles(50);
    if (err_cnt == 0 && pending_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
